// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/amqpd_pkg.sv =====
package amqpd_pkg;

	// Frame status codes reported at frame_done.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_BAD   = 2'd1;
	localparam logic [1:0] STATUS_PROTO = 2'd2;

	// One result transaction of the deframer.
	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic [1:0]  frame_status;
		logic [7:0]  frame_kind;
		logic [15:0] channel_number;
		logic [31:0] frame_size;
		logic [15:0] class_code;
		logic [15:0] method_code;
		logic        marker_in_payload;
	} result_t;

endpackage

// ===== src/amqpd_parser.sv =====
module amqpd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	output amqpd_pkg::result_t res
);
	import amqpd_pkg::*;

	// Parser phase codes.
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_END     = 2'd2;
	localparam logic [1:0] PH_PROTO   = 2'd3;

	localparam logic [7:0] END_MARK = 8'hCE;
	localparam logic [7:0] CHAR_A   = 8'h41;
	localparam logic [7:0] CHAR_M   = 8'h4D;
	localparam logic [7:0] CHAR_Q   = 8'h51;
	localparam logic [7:0] CHAR_P   = 8'h50;

	logic [1:0]  phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] size_q, size_d;
	logic [15:0] class_q, class_d;
	logic [15:0] method_q, method_d;
	logic        prefix_q, prefix_d;
	logic        marker_q, marker_d;
	logic [31:0] pos_inc;
	logic [31:0] size_shift;

	assign pos_inc    = pos_q + 32'd1;
	assign size_shift = {size_q[23:0], data_byte};

	// Next state and result for the current byte.
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		type_d   = type_q;
		chan_d   = chan_q;
		size_d   = size_q;
		class_d  = class_q;
		method_d = method_q;
		prefix_d = prefix_q;
		marker_d = marker_q;
		res      = '0;

		case (phase_q)
			PH_HEADER: begin
				if (pos_q == 32'd0) begin
					// Type byte starts a new frame and clears the held fields.
					type_d   = data_byte;
					chan_d   = '0;
					size_d   = '0;
					class_d  = '0;
					method_d = '0;
					marker_d = 1'b0;
					prefix_d = (data_byte == CHAR_A);
					pos_d    = 32'd1;
				end else if (pos_q <= 32'd2) begin
					chan_d = {chan_q[7:0], data_byte};
					if (prefix_q && data_byte != ((pos_q == 32'd1) ? CHAR_M : CHAR_Q)) begin
						prefix_d = 1'b0;
					end
					pos_d = pos_inc;
				end else if (pos_q == 32'd3 && prefix_q && data_byte == CHAR_P) begin
					// "AMQP" seen: switch to the protocol header.
					type_d   = '0;
					chan_d   = '0;
					size_d   = '0;
					prefix_d = 1'b0;
					phase_d  = PH_PROTO;
					pos_d    = 32'd4;
				end else begin
					prefix_d = 1'b0;
					size_d   = size_shift;
					if (pos_q >= 32'd6) begin
						pos_d   = '0;
						phase_d = (size_shift == 32'd0) ? PH_END : PH_PAYLOAD;
					end else begin
						pos_d = pos_inc;
					end
				end
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = data_byte;
				if (data_byte == END_MARK) begin
					marker_d = 1'b1;
				end
				// Method frames carry class and method ids in the first four bytes.
				if (type_q == 8'd1) begin
					case (pos_q)
						32'd0:   class_d  = class_q  | {data_byte, 8'h00};
						32'd1:   class_d  = class_q  | {8'h00, data_byte};
						32'd2:   method_d = method_q | {data_byte, 8'h00};
						32'd3:   method_d = method_q | {8'h00, data_byte};
						default: ;
					endcase
				end
				if (pos_inc >= size_q) begin
					pos_d   = '0;
					phase_d = PH_END;
				end else begin
					pos_d = pos_inc;
				end
			end
			PH_END: begin
				res.frame_done        = 1'b1;
				res.frame_status      = (data_byte == END_MARK) ? STATUS_OK : STATUS_BAD;
				res.marker_in_payload = marker_q;
				pos_d                 = '0;
				phase_d               = PH_HEADER;
			end
			default: begin
				// Protocol header version bytes pass through.
				res.payload_valid = 1'b1;
				res.payload_byte  = data_byte;
				if (pos_q >= 32'd7) begin
					res.frame_done   = 1'b1;
					res.frame_status = STATUS_PROTO;
					pos_d            = '0;
					phase_d          = PH_HEADER;
				end else begin
					pos_d = pos_inc;
				end
			end
		endcase

		res.frame_kind     = type_d;
		res.channel_number = chan_d;
		res.frame_size     = size_d;
		res.class_code     = class_d;
		res.method_code    = method_d;
	end

	// State registers advance once per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			type_q   <= '0;
			chan_q   <= '0;
			size_q   <= '0;
			class_q  <= '0;
			method_q <= '0;
			prefix_q <= 1'b0;
			marker_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			type_q   <= type_d;
			chan_q   <= chan_d;
			size_q   <= size_d;
			class_q  <= class_d;
			method_q <= method_d;
			prefix_q <= prefix_d;
			marker_q <= marker_d;
		end
	end

endmodule

// ===== src/amqp_frame_deframer.sv =====
// Channel | Handshake          | Payload
// input   | in_valid/in_stall   | data_byte
// output  | out_valid/out_stall | payload_valid .. marker_in_payload
//
// One byte is accepted per cycle while in_stall is low; a taken byte goes through
// the input register, one pass of the parse logic and the result register before
// its result is on the outputs. Reset (arst_n low) empties both registers and
// returns the parser to wait for a frame type byte. out_stall holds the result
// register, and in_stall rises only while the input register is full and cannot
// move on.
module amqp_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        frame_done,
	output logic [1:0]  frame_status,
	output logic [7:0]  frame_kind,
	output logic [15:0] channel_number,
	output logic [31:0] frame_size,
	output logic [15:0] class_code,
	output logic [15:0] method_code,
	output logic        marker_in_payload
);
	import amqpd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_next;
	logic       adv;

	// The input stage moves on when the result register is free or drained.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	amqpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (data_s1),
		.res       (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid         = valid_s2;
	assign payload_valid     = res_s2.payload_valid;
	assign payload_byte      = res_s2.payload_byte;
	assign frame_done        = res_s2.frame_done;
	assign frame_status      = res_s2.frame_status;
	assign frame_kind        = res_s2.frame_kind;
	assign channel_number    = res_s2.channel_number;
	assign frame_size        = res_s2.frame_size;
	assign class_code        = res_s2.class_code;
	assign method_code       = res_s2.method_code;
	assign marker_in_payload = res_s2.marker_in_payload;

	// Assertions.
`include "assert_macros.svh"
	`ASSERT_IMPL(a_idle_fields, out_valid && !frame_done, frame_status == STATUS_OK && !marker_in_payload, "status or marker set without frame_done")
	`ASSERT_IMPL(a_proto_only, out_valid && payload_valid && frame_done, frame_status == STATUS_PROTO && !marker_in_payload, "payload byte on a frame end byte")
	`ASSERT_IMPL(a_byte_zero, out_valid && !payload_valid, payload_byte == 8'd0, "payload byte not cleared")
	`ASSERT_NEXT(a_no_loss, in_stall, valid_s1, "stalled input transaction lost")

endmodule
